>>> rtl/core/sjf_pkg.sv
package sjf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 16;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned TIME_IN_W       = 16;

  // request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_SCHED = 1'b1;

  // outgoing process states
  localparam logic [1:0] PSTATE_READY    = 2'd0;
  localparam logic [1:0] PSTATE_BLOCKED  = 2'd1;
  localparam logic [1:0] PSTATE_FINISHED = 2'd2;
  localparam logic [1:0] PSTATE_INVALID  = 2'd3;

  typedef enum logic [2:0] {
    ROUTE_NONE     = 3'd0,
    ROUTE_READY    = 3'd1,
    ROUTE_BLOCKED  = 3'd2,
    ROUTE_FINISHED = 3'd3,
    ROUTE_ERROR    = 3'd4
  } route_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_SHIFT,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/core/sjf_ready_queue_select.sv
// Shortest-job-first ready table. An add beat appends a process (id and
// remaining time) to the table in arrival order; overflow_o flags a dropped
// insert when the table is full. A schedule beat first routes the outgoing
// process (ready goes back into the table, blocked and finished are only
// reported, an invalid state reports an error), then picks the entry with
// the least remaining time (earliest on ties), removes it while keeping the
// order of the rest, and returns it. Each input beat gives exactly one
// result beat. An add, or a schedule that finds the table empty, skips
// the scan and goes to the result state. A schedule first scans every
// entry (after the insert) for the minimum at one memory read a cycle,
// takes a pick step, then closes the gap left by the picked entry at
// one read and one write a cycle over the entries that follow it. The
// table is a single memory with one write and one registered read port,
// and that port pair sets the rate.
// in_ready_o is high only while the sequencer is idle; a finished result
// waits in the output register, and a new beat can be taken meanwhile.
module sjf_ready_queue_select #(
  parameter int unsigned QUEUE_DEPTH = sjf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = sjf_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic                             has_current_i,
  input  logic [1:0]                       proc_state_i,
  input  logic [sjf_pkg::ID_W-1:0]         proc_id_i,
  input  logic [sjf_pkg::TIME_IN_W-1:0]    remaining_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             picked_valid_o,
  output logic [sjf_pkg::ID_W-1:0]         picked_id_o,
  output logic [sjf_pkg::TIME_IN_W-1:0]    picked_time_o,
  output sjf_pkg::route_e                  routed_to_o,
  output logic                             overflow_o
);

  import sjf_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = ID_W + TIME_BITS;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;      // read pointer for scan and shift
  logic             pend_q, pend_d;    // a read is in flight
  logic [IDX_W-1:0] pidx_q, pidx_d;    // scan: index in flight, shift: write target
  route_e           routed_q, routed_d;
  logic             ovf_q, ovf_d;
  logic             pick_q, pick_d;

  logic                 out_valid_q, out_valid_d;
  logic                 res_pick_q;
  logic [ID_W-1:0]      res_id_q;
  logic [TIME_IN_W-1:0] res_time_q;
  route_e               res_route_q;
  logic                 res_ovf_q;
  logic                 load;

  // incoming beat decode
  logic                 push, full, do_push;
  logic [CNT_W-1:0]     cnt_push;
  route_e               route_in;
  logic [31:0]          t_ext;
  logic [TIME_BITS-1:0] t_store;

  // table memory
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  // minimum tracker
  logic                 smp;
  logic [TIME_BITS-1:0] best_time;
  logic [ID_W-1:0]      best_id;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS+TIME_IN_W-1:0] bt_ext;

  assign t_ext   = {{(32 - TIME_IN_W){1'b0}}, remaining_time_i};
  assign t_store = t_ext[TIME_BITS-1:0];

  assign push = (req_type_i == REQ_ADD) ||
                (has_current_i && (proc_state_i == PSTATE_READY));
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign cnt_push = count_q + CNT_W'(do_push);

  always_comb begin
    route_in = ROUTE_NONE;
    if ((req_type_i == REQ_SCHED) && has_current_i) begin
      case (proc_state_i)
        PSTATE_READY:    route_in = ROUTE_READY;
        PSTATE_BLOCKED:  route_in = ROUTE_BLOCKED;
        PSTATE_FINISHED: route_in = ROUTE_FINISHED;
        PSTATE_INVALID:  route_in = ROUTE_ERROR;
        default:         route_in = ROUTE_ERROR;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if ((req_type_i == REQ_ADD) || (cnt_push == '0)) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if ((idx_q >= count_q) && !pend_q) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if ((idx_q >= count_q) && !pend_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer datapath control
  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    routed_d  = routed_q;
    ovf_d     = ovf_q;
    pick_d    = pick_q;
    ram_we    = 1'b0;
    ram_waddr = pidx_q;
    ram_wdata = ram_rdata;
    smp       = 1'b0;
    load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          count_d   = cnt_push;
          routed_d  = route_in;
          ovf_d     = push && full;
          pick_d    = (req_type_i == REQ_SCHED) && (cnt_push != '0);
          ram_we    = do_push;
          ram_waddr = count_q[IDX_W-1:0];
          ram_wdata = {proc_id_i, t_store};
        end
      end
      ST_SCAN: begin
        smp = pend_q;
        if (idx_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + 1'b1;
        end
      end
      ST_PICK: begin
        // compaction starts at the entry after the pick
        idx_d = CNT_W'(best_idx) + 1'b1;
      end
      ST_SHIFT: begin
        ram_we = pend_q;
        if (idx_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = IDX_W'(idx_q - 1'b1);
          idx_d  = idx_q + 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - 1'b1;
        end
      end
      ST_EMIT: begin
        load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  sjf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  sjf_min_unit #(
    .IDX_W     (IDX_W),
    .TIME_BITS (TIME_BITS)
  ) u_min (
    .clk_i       (clk_i),
    .sample_i    (smp),
    .first_i     (pidx_q == '0),
    .time_i      (ram_rdata[TIME_BITS-1:0]),
    .id_i        (ram_rdata[ENT_W-1:TIME_BITS]),
    .idx_i       (pidx_q),
    .best_time_o (best_time),
    .best_id_o   (best_id),
    .best_idx_o  (best_idx)
  );

  assign bt_ext = {{TIME_IN_W{1'b0}}, best_time};

  // result register, freed by the output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      routed_q    <= ROUTE_NONE;
      ovf_q       <= 1'b0;
      pick_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pidx_q      <= pidx_d;
      routed_q    <= routed_d;
      ovf_q       <= ovf_d;
      pick_q      <= pick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_pick_q  <= pick_q;
      res_id_q    <= pick_q ? best_id : '0;
      res_time_q  <= pick_q ? bt_ext[TIME_IN_W-1:0] : '0;
      res_route_q <= routed_q;
      res_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign picked_valid_o = res_pick_q;
  assign picked_id_o    = res_id_q;
  assign picked_time_o  = res_time_q;
  assign routed_to_o    = res_route_q;
  assign overflow_o     = res_ovf_q;

endmodule

>>> rtl/core/sjf_ram.sv
module sjf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sjf_min_unit.sv
module sjf_min_unit #(
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        sample_i,
  input  logic                        first_i,
  input  logic [TIME_BITS-1:0]        time_i,
  input  logic [sjf_pkg::ID_W-1:0]    id_i,
  input  logic [IDX_W-1:0]            idx_i,
  output logic [TIME_BITS-1:0]        best_time_o,
  output logic [sjf_pkg::ID_W-1:0]    best_id_o,
  output logic [IDX_W-1:0]            best_idx_o
);

  import sjf_pkg::*;

  logic [TIME_BITS-1:0] best_time_q, best_time_d;
  logic [ID_W-1:0]      best_id_q, best_id_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic                 take;

  // strict less keeps the earliest entry on ties
  assign take = sample_i && (first_i || (time_i < best_time_q));

  always_comb begin
    best_time_d = best_time_q;
    best_id_d   = best_id_q;
    best_idx_d  = best_idx_q;
    if (take) begin
      best_time_d = time_i;
      best_id_d   = id_i;
      best_idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_time_q <= best_time_d;
    best_id_q   <= best_id_d;
    best_idx_q  <= best_idx_d;
  end

  assign best_time_o = best_time_q;
  assign best_id_o   = best_id_q;
  assign best_idx_o  = best_idx_q;

endmodule
